[hw/rtl/ltu_pkg.sv]
// Shared types, constants and the ISO 8859-2 code point table for the transcoder.
`timescale 1ns / 1ps
`default_nettype none

package ltu_pkg;

    // Source encoding codes held in the configuration register
    localparam logic ENC_LATIN1 = 1'b0;
    localparam logic ENC_LATIN2 = 1'b1;

    // Byte range boundaries
    localparam logic [7:0] C1_FIRST     = 8'h80;
    localparam logic [7:0] MAPPED_FIRST = 8'hA0;

    // UTF-8 two-byte prefixes
    localparam logic [2:0] UTF8_LEAD_TAG  = 3'b110;
    localparam logic [1:0] UTF8_TRAIL_TAG = 2'b10;

    // Default depth of the queue between front and back
    localparam int LTU_QUEUE_DEPTH = 2;

    localparam int CP_W        = 11;
    localparam int ISO2_ENTRIES = 96;

    localparam logic [CP_W-1:0] ISO2_POINTS [ISO2_ENTRIES] = '{
        11'h0A0, 11'h104, 11'h2D8, 11'h141, 11'h0A4, 11'h13D, 11'h15A, 11'h0A7,
        11'h0A8, 11'h160, 11'h15E, 11'h164, 11'h179, 11'h0AD, 11'h17D, 11'h17B,
        11'h0B0, 11'h105, 11'h2DB, 11'h142, 11'h0B4, 11'h13E, 11'h15B, 11'h2C7,
        11'h0B8, 11'h161, 11'h15F, 11'h165, 11'h17A, 11'h2DD, 11'h17E, 11'h17C,
        11'h154, 11'h0C1, 11'h0C2, 11'h102, 11'h0C4, 11'h139, 11'h106, 11'h0C7,
        11'h10C, 11'h0C9, 11'h118, 11'h0CB, 11'h11A, 11'h0CD, 11'h0CE, 11'h10E,
        11'h110, 11'h143, 11'h147, 11'h0D3, 11'h0D4, 11'h150, 11'h0D6, 11'h0D7,
        11'h158, 11'h16E, 11'h0DA, 11'h170, 11'h0DC, 11'h0DD, 11'h162, 11'h0DF,
        11'h155, 11'h0E1, 11'h0E2, 11'h103, 11'h0E4, 11'h13A, 11'h107, 11'h0E7,
        11'h10D, 11'h0E9, 11'h119, 11'h0EB, 11'h11B, 11'h0ED, 11'h0EE, 11'h10F,
        11'h111, 11'h144, 11'h148, 11'h0F3, 11'h0F4, 11'h151, 11'h0F6, 11'h0F7,
        11'h159, 11'h16F, 11'h0FA, 11'h171, 11'h0FC, 11'h0FD, 11'h163, 11'h2D9
    };

    // Byte classes seen by the front end
    typedef enum logic [1:0] {
        CLS_DROP,
        CLS_ASCII,
        CLS_MAPPED
    } ltu_class_t;

    // One classified transaction waiting for the back end
    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] trail;
        logic       pair;
    } ltu_item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic      valid;
        ltu_item_t item;
    } ltu_head_t;

    function automatic logic [CP_W-1:0] iso2_point(input logic [6:0] idx);
        logic [CP_W-1:0] cp;
        cp = '0;
        if (idx < 7'(ISO2_ENTRIES))
        begin
            cp = ISO2_POINTS[idx];
        end
        return cp;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ltu_if.sv]
// Channel interfaces: source bytes, UTF-8 result bytes and the configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface ltu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface ltu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface ltu_cfg_if;
    logic valid;
    logic ready;
    logic encoding_select;

    modport source (output valid, output encoding_select, input ready);
    modport sink   (input valid, input encoding_select, output ready);
endinterface

`default_nettype wire

[hw/rtl/ltu_front.sv]
// Front end: accept source bytes, classify them and build UTF-8 byte pairs.
`timescale 1ns / 1ps
`default_nettype none

module ltu_front (
    ltu_in_if.sink             src_ch,
    input  wire logic          encoding_select,
    input  wire logic          push_ready,
    output logic               push_valid,
    output ltu_pkg::ltu_item_t push_item
);
    import ltu_pkg::*;

    ltu_class_t      cls;
    logic [CP_W-1:0] cp;
    logic [7:0]      offset;

    assign src_ch.ready = push_ready;
    assign offset       = src_ch.in_byte - MAPPED_FIRST;

    always_comb
    begin
        if (src_ch.in_byte == 8'h00)
        begin
            cls = CLS_DROP;
        end
        else if (src_ch.in_byte < C1_FIRST)
        begin
            cls = CLS_ASCII;
        end
        else if (src_ch.in_byte < MAPPED_FIRST)
        begin
            cls = CLS_DROP;
        end
        else
        begin
            cls = CLS_MAPPED;
        end
    end

    always_comb
    begin
        if (encoding_select == ENC_LATIN2)
        begin
            cp = iso2_point(offset[6:0]);
        end
        else
        begin
            cp = {3'b000, src_ch.in_byte};
        end
    end

    always_comb
    begin
        push_item  = '0;
        push_valid = 1'b0;
        case (cls)
            CLS_ASCII:
            begin
                push_item.lead = src_ch.in_byte;
                push_item.pair = 1'b0;
                push_valid     = src_ch.valid;
            end
            CLS_MAPPED:
            begin
                push_item.lead  = {UTF8_LEAD_TAG, cp[10:6]};
                push_item.trail = {UTF8_TRAIL_TAG, cp[5:0]};
                push_item.pair  = 1'b1;
                push_valid      = src_ch.valid;
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/ltu_queue.sv]
// Small FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module ltu_queue #(
    parameter int DEPTH = ltu_pkg::LTU_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    input  wire ltu_pkg::ltu_item_t push_item,
    output logic                    push_ready,
    output ltu_pkg::ltu_head_t      head,
    input  wire logic               pop
);
    import ltu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ltu_item_t        entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ltu_back.sv]
// Back end: emit queued items one UTF-8 byte per cycle, unless res_ch stalls, through an output register.
`timescale 1ns / 1ps
`default_nettype none

module ltu_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ltu_pkg::ltu_head_t head,
    output logic                    pop,
    ltu_out_if.source               res_ch
);
    import ltu_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       phase_reg, phase_next;
    logic       load_ok;

    assign load_ok = !out_valid_reg || res_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;
        if (load_ok)
        begin
            out_valid_next = 1'b0;
            if (head.valid)
            begin
                out_valid_next = 1'b1;
                if (phase_reg)
                begin
                    // second byte of a pair: finish the transaction
                    out_byte_next = head.item.trail;
                    out_last_next = 1'b1;
                    phase_next    = 1'b0;
                    pop           = 1'b1;
                end
                else if (head.item.pair)
                begin
                    // lead byte: hold the entry for its trail byte
                    out_byte_next = head.item.lead;
                    out_last_next = 1'b0;
                    phase_next    = 1'b1;
                end
                else
                begin
                    out_byte_next = head.item.lead;
                    out_last_next = 1'b1;
                    pop           = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign res_ch.valid    = out_valid_reg;
    assign res_ch.out_byte = out_byte_reg;
    assign res_ch.out_last = out_last_reg;

endmodule

`default_nettype wire

[hw/rtl/latin_to_utf8_transcoder_unit.sv]
// Top level of the Latin-1 / Latin-2 to UTF-8 transcoder.
//
//  channel  | dir | payload                 | transaction moves
//  ---------+-----+-------------------------+-------------------------------
//  src_ch   | in  | in_byte[7:0]            | one source byte
//  res_ch   | out | out_byte[7:0], out_last | one UTF-8 byte, last of its source
//  cfg_ch   | in  | encoding_select         | source encoding, 0 Latin-1, 1 Latin-2
//
// A source byte in 0x01..0x7F yields one UTF-8 byte, a byte in 0xA0..0xFF yields two;
// the output register sets the rate, one UTF-8 byte per cycle while res_ch is ready.
// Dropped bytes (zero, 0x80..0x9F) are accepted and produce nothing.
// The first result byte passes through the queue and then the output register
// before it is presented on res_ch.
// Reset selects Latin-1 and empties the queue; no clearing pass is needed.
// src_ch stalls only while the front/back queue is full; cfg_ch never stalls.
`timescale 1ns / 1ps
`default_nettype none

module latin_to_utf8_transcoder_unit #(
    parameter int QUEUE_DEPTH = ltu_pkg::LTU_QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ltu_in_if.sink     src_ch,
    ltu_out_if.source  res_ch,
    ltu_cfg_if.sink    cfg_ch
);
    import ltu_pkg::*;

    logic      encoding_select_reg;
    logic      encoding_select_next;
    logic      push_valid;
    logic      push_ready;
    ltu_item_t push_item;
    ltu_head_t head;
    logic      pop;

    // Configuration register: always ready; to be written only while idle, unenforced
    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        encoding_select_next = encoding_select_reg;
        if (cfg_ch.valid)
        begin
            encoding_select_next = cfg_ch.encoding_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_select_reg <= ENC_LATIN1;
        end
        else
        begin
            encoding_select_reg <= encoding_select_next;
        end
    end

    // Front: classify and map each source byte
    ltu_front u_front (
        .src_ch          (src_ch),
        .encoding_select (encoding_select_reg),
        .push_ready      (push_ready),
        .push_valid      (push_valid),
        .push_item       (push_item)
    );

    // Queue: decouple front acceptance from back emission
    ltu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    // Back: advance one UTF-8 byte per cycle into the output register unless res_ch stalls
    ltu_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .res_ch (res_ch)
    );

endmodule

`default_nettype wire

[hw/rtl/ltu_checker.sv]
// Port-level checker for the transcoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ltu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last
);
    import ltu_pkg::*;

    // Hold a stalled result valid
    a_res_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    // Hold a stalled result payload
    a_res_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(out_byte) && $stable(out_last))
        else $error("result payload changed while stalled");

    // A byte that is not last must be a UTF-8 lead byte
    a_lead_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_last |-> out_byte[7:5] == UTF8_LEAD_TAG)
        else $error("non-last byte is not a two-byte lead");

    // A last byte with the top bit set must be a continuation byte
    a_trail_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_last && out_byte[7] |-> out_byte[7:6] == UTF8_TRAIL_TAG)
        else $error("last byte is neither ASCII nor continuation");

    // A taken lead byte is followed at once by its continuation byte
    a_trail_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !out_last
        |=> res_valid && out_last && out_byte[7:6] == UTF8_TRAIL_TAG)
        else $error("lead byte not followed by its continuation");

endmodule

bind latin_to_utf8_transcoder_unit ltu_checker u_ltu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_ch.valid),
    .res_ready (res_ch.ready),
    .out_byte  (res_ch.out_byte),
    .out_last  (res_ch.out_last)
);

`default_nettype wire
